// ===== hdl/aht_pkg.sv =====
// shared types and constants for the advertiser address hit table
package aht_pkg;

  localparam int KEY_W     = 48;
  localparam int CHAN_W    = 6;
  localparam int CNT_W     = 32;
  localparam int TIME_W    = 32;
  localparam int IDX_W     = 4;
  localparam int OCC_W     = 5;
  localparam int OUTCOME_W = 3;

  localparam logic [KEY_W-1:0] KEY_ZERO = '0;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;

  // result codes
  typedef enum logic [OUTCOME_W-1:0] {
    OC_REJECTED  = 3'd0,
    OC_MATCHED   = 3'd1,
    OC_INSERTED  = 3'd2,
    OC_DROPPED   = 3'd3,
    OC_READ_OCC  = 3'd4,
    OC_READ_EMPT = 3'd5
  } outcome_t;

  // command codes
  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_READ    = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_EMIT
  } state_t;

  // one table entry as it sits in memory
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CHAN_W-1:0] channel;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] last_seen;
  } entry_t;

  // latched input word
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] timestamp;
    logic [IDX_W-1:0]  read_index;
  } item_t;

  // result word
  typedef struct packed {
    outcome_t          outcome;
    logic [IDX_W-1:0]  entry_index;
    entry_t            entry;
    logic [OCC_W-1:0]  occupied;
    logic [CNT_W-1:0]  total_captured;
  } result_t;

endpackage

// ===== hdl/aht_in_if.sv =====
// input channel of the hit table: command word with valid/ready
interface aht_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [aht_pkg::KEY_W-1:0]    key;
  logic [aht_pkg::CHAN_W-1:0]   channel;
  logic [aht_pkg::TIME_W-1:0]   timestamp;
  logic [aht_pkg::IDX_W-1:0]    read_index;

  modport source (output valid, command, key, channel, timestamp, read_index,
                  input ready);
  modport sink   (input valid, command, key, channel, timestamp, read_index,
                  output ready);
endinterface

// ===== hdl/aht_out_if.sv =====
// result channel of the hit table: result word with valid/ready
interface aht_out_if;
  logic                           valid;
  logic                           ready;
  logic [aht_pkg::OUTCOME_W-1:0]  outcome;
  logic [aht_pkg::IDX_W-1:0]      entry_index;
  logic [aht_pkg::KEY_W-1:0]      entry_key;
  logic [aht_pkg::CHAN_W-1:0]     entry_channel;
  logic [aht_pkg::CNT_W-1:0]      entry_count;
  logic [aht_pkg::TIME_W-1:0]     entry_last_seen;
  logic [aht_pkg::OCC_W-1:0]      occupied;
  logic [aht_pkg::CNT_W-1:0]      total_captured;

  modport source (output valid, outcome, entry_index, entry_key, entry_channel,
                  entry_count, entry_last_seen, occupied, total_captured,
                  input ready);
  modport sink   (input valid, outcome, entry_index, entry_key, entry_channel,
                  entry_count, entry_last_seen, occupied, total_captured,
                  output ready);
endinterface

// ===== hdl/advertiser_address_hit_table_core.sv =====
// top level of the advertiser address hit table: memory, scan sequencer, result register
//
// Keeps up to TABLE_DEPTH learned 48-bit advertiser keys, each with a hit
// count, the last channel and the last-seen time, in one single-port-write,
// registered-read memory. A capture word walks the occupied entries in
// insertion order, one memory read issued per cycle with the compare in the
// cycle after that read. The block holds one word at a time: in_ch.ready is
// high while the sequencer is idle, and a finished result sits in the output
// register until taken, so the next word can be accepted while the previous
// result still waits. Each word yields exactly one result word. The table
// needs no clearing pass after reset: data of entries at or beyond the fill
// count is never used, so a fresh table is usable in the first cycle after
// reset. Memory writes only happen at the end of a scan, after the last read
// whose data that word uses, so no write meets a read whose data is used.
module advertiser_address_hit_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  aht_in_if.sink     in_ch,
  aht_out_if.source  out_ch
);

  // address width into the table and width of the fill counter
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // sequencer state
  aht_pkg::state_t  state_r, state_nxt;

  // latched word and scan bookkeeping
  aht_pkg::item_t   item_r, item_nxt;
  logic [CW-1:0]    issue_r, issue_nxt;     // next entry to read
  logic             rd_v_r, rd_v_nxt;       // a read is in flight
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;   // entry of the read in flight

  // table bookkeeping
  logic [CW-1:0]           used_r, used_nxt;
  logic [aht_pkg::CNT_W-1:0] total_r, total_nxt;

  // result staging and output register
  aht_pkg::result_t res_r, res_nxt;
  aht_pkg::result_t out_res_r;
  logic             out_valid_r;
  logic             out_load;

  // table memory
  aht_pkg::entry_t  mem [TABLE_DEPTH];
  aht_pkg::entry_t  rd_data_r;
  logic [AW-1:0]    rd_addr_raw;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  aht_pkg::entry_t  mem_wdata;

  logic             in_fire;
  logic             key_bad;
  logic             read_hit;
  logic             key_match;
  aht_pkg::entry_t  upd_entry;
  aht_pkg::entry_t  new_entry;

  assign in_ch.ready = (state_r == aht_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // all-zero and all-ones keys are never learned
  assign key_bad  = (in_ch.key == aht_pkg::KEY_ZERO) || (in_ch.key == aht_pkg::KEY_ONES);

  // read-back is served only for an entry that is in use
  assign read_hit = (int'(in_ch.read_index) < int'(used_r)) &&
                    (int'(in_ch.read_index) < TABLE_DEPTH);

  assign key_match = rd_v_r && (rd_data_r.key == item_r.key);

  // entry after a hit: bump count, refresh channel and time
  always_comb begin
    upd_entry           = rd_data_r;
    upd_entry.count     = rd_data_r.count + aht_pkg::CNT_W'(1);
    upd_entry.channel   = item_r.channel;
    upd_entry.last_seen = item_r.timestamp;
  end

  // freshly learned entry
  always_comb begin
    new_entry.key       = item_r.key;
    new_entry.channel   = item_r.channel;
    new_entry.count     = aht_pkg::CNT_W'(1);
    new_entry.last_seen = item_r.timestamp;
  end

  // read address: requested entry when idle, scan pointer otherwise
  assign rd_addr_raw = (state_r == aht_pkg::S_IDLE) ? AW'(in_ch.read_index) : AW'(issue_r);
  assign rd_addr     = (int'(rd_addr_raw) < TABLE_DEPTH) ? rd_addr_raw : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aht_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.command == aht_pkg::CMD_READ) begin
            state_nxt = read_hit ? aht_pkg::S_READ : aht_pkg::S_EMIT;
          end else begin
            state_nxt = key_bad ? aht_pkg::S_EMIT : aht_pkg::S_SCAN;
          end
        end
      end
      aht_pkg::S_READ: begin
        state_nxt = aht_pkg::S_EMIT;
      end
      aht_pkg::S_SCAN: begin
        if (key_match || !(issue_r < used_r)) begin
          state_nxt = aht_pkg::S_EMIT;
        end
      end
      aht_pkg::S_EMIT: begin
        if (out_load) begin
          state_nxt = aht_pkg::S_IDLE;
        end
      end
      default: state_nxt = aht_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    item_nxt   = item_r;
    issue_nxt  = issue_r;
    rd_v_nxt   = rd_v_r;
    rd_idx_nxt = rd_idx_r;
    used_nxt   = used_r;
    total_nxt  = total_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = rd_idx_r;
    mem_wdata  = upd_entry;
    out_load   = 1'b0;

    case (state_r)
      aht_pkg::S_IDLE: begin
        if (in_fire) begin
          item_nxt.key        = in_ch.key;
          item_nxt.channel    = in_ch.channel;
          item_nxt.timestamp  = in_ch.timestamp;
          item_nxt.read_index = in_ch.read_index;
          issue_nxt           = '0;
          rd_v_nxt            = 1'b0;
          // results that need no table access are settled right away
          res_nxt.entry          = '0;
          res_nxt.entry_index    = '0;
          res_nxt.occupied       = aht_pkg::OCC_W'(used_r);
          res_nxt.total_captured = total_r;
          if (in_ch.command == aht_pkg::CMD_READ) begin
            res_nxt.outcome     = aht_pkg::OC_READ_EMPT;
            res_nxt.entry_index = in_ch.read_index;
          end else begin
            res_nxt.outcome     = aht_pkg::OC_REJECTED;
          end
        end
      end
      aht_pkg::S_READ: begin
        res_nxt.outcome     = aht_pkg::OC_READ_OCC;
        res_nxt.entry_index = item_r.read_index;
        res_nxt.entry       = rd_data_r;
      end
      aht_pkg::S_SCAN: begin
        if (key_match) begin
          // hit: write back the refreshed entry
          mem_we                 = 1'b1;
          mem_waddr              = rd_idx_r;
          mem_wdata              = upd_entry;
          total_nxt              = total_r + aht_pkg::CNT_W'(1);
          rd_v_nxt               = 1'b0;
          res_nxt.outcome        = aht_pkg::OC_MATCHED;
          res_nxt.entry_index    = aht_pkg::IDX_W'(rd_idx_r);
          res_nxt.entry          = upd_entry;
          res_nxt.occupied       = aht_pkg::OCC_W'(used_r);
          res_nxt.total_captured = total_r + aht_pkg::CNT_W'(1);
        end else if (issue_r < used_r) begin
          // keep the read stream going, compare follows in the next cycle
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = AW'(issue_r);
          issue_nxt  = issue_r + CW'(1);
        end else begin
          rd_v_nxt = 1'b0;
          if (int'(used_r) < TABLE_DEPTH) begin
            // miss with room left: append
            mem_we                 = 1'b1;
            mem_waddr              = AW'(used_r);
            mem_wdata              = new_entry;
            used_nxt               = used_r + CW'(1);
            total_nxt              = total_r + aht_pkg::CNT_W'(1);
            res_nxt.outcome        = aht_pkg::OC_INSERTED;
            res_nxt.entry_index    = aht_pkg::IDX_W'(used_r);
            res_nxt.entry          = new_entry;
            res_nxt.occupied       = aht_pkg::OCC_W'(used_r + CW'(1));
            res_nxt.total_captured = total_r + aht_pkg::CNT_W'(1);
          end else begin
            // miss on a full table: drop
            res_nxt.outcome        = aht_pkg::OC_DROPPED;
            res_nxt.entry_index    = '0;
            res_nxt.entry          = '0;
            res_nxt.occupied       = aht_pkg::OCC_W'(used_r);
            res_nxt.total_captured = total_r;
          end
        end
      end
      aht_pkg::S_EMIT: begin
        // move into the output register once it is free or being emptied
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aht_pkg::S_IDLE;
      used_r      <= '0;
      total_r     <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      total_r <= total_nxt;
      rd_v_r  <= rd_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    issue_r  <= issue_nxt;
    rd_idx_r <= rd_idx_nxt;
    res_r    <= res_nxt;
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // result channel
  assign out_ch.valid           = out_valid_r;
  assign out_ch.outcome         = out_res_r.outcome;
  assign out_ch.entry_index     = out_res_r.entry_index;
  assign out_ch.entry_key       = out_res_r.entry.key;
  assign out_ch.entry_channel   = out_res_r.entry.channel;
  assign out_ch.entry_count     = out_res_r.entry.count;
  assign out_ch.entry_last_seen = out_res_r.entry.last_seen;
  assign out_ch.occupied        = out_res_r.occupied;
  assign out_ch.total_captured  = out_res_r.total_captured;

  // fill count never passes the table size
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(used_r) <= TABLE_DEPTH)
    else $error("fill count beyond table depth");

  // fill count grows by at most one per word, never shrinks
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r == $past(used_r)) || (used_r == $past(used_r) + CW'(1)))
    else $error("fill count jumped");

  // total advances only together with a table write
  a_total_write: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != $past(total_r)) |-> $past(mem_we))
    else $error("total moved without a table write");

  // table is written only at the end of a scan, never while idle
  a_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == aht_pkg::S_SCAN) && (state_nxt == aht_pkg::S_EMIT))
    else $error("table write outside scan end");

endmodule

// ===== test/aht_hit_checker.sv =====
// result checker for the hit table: mirrors the entry store and checks each result word
module aht_hit_checker #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  aht_in_if    in_mon,
  aht_out_if   out_mon,
  output int   bad_words,
  output int   pending,
  output int   n_inserted,
  output int   n_matched,
  output int   n_dropped,
  output int   n_rejected,
  output int   n_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    aht_pkg::outcome_t          outcome;
    logic [aht_pkg::IDX_W-1:0]  idx;
    logic [aht_pkg::KEY_W-1:0]  key;
    logic [aht_pkg::CHAN_W-1:0] chan;
    logic [aht_pkg::CNT_W-1:0]  count;
    logic [aht_pkg::TIME_W-1:0] seen;
    logic [aht_pkg::OCC_W-1:0]  occ;
    logic [aht_pkg::CNT_W-1:0]  total;
  } hit_reply_t;

  logic [aht_pkg::KEY_W-1:0]  learned_key   [DEPTH];
  logic [aht_pkg::CHAN_W-1:0] learned_chan  [DEPTH];
  logic [aht_pkg::CNT_W-1:0]  learned_count [DEPTH];
  logic [aht_pkg::TIME_W-1:0] learned_seen  [DEPTH];
  int unsigned                fill_level;
  logic [aht_pkg::CNT_W-1:0]  capture_sum;

  hit_reply_t replies_due[$];

  // applies one word to the entry store and returns the reply it should give
  function automatic hit_reply_t table_response(logic cmd,
                                                logic [aht_pkg::KEY_W-1:0] key,
                                                logic [aht_pkg::CHAN_W-1:0] chan,
                                                logic [aht_pkg::TIME_W-1:0] ts,
                                                logic [aht_pkg::IDX_W-1:0] ridx);
    hit_reply_t r;
    int         slot;
    r    = '0;
    slot = -1;
    if (cmd == aht_pkg::CMD_READ) begin
      if (int'(ridx) < int'(fill_level) && int'(ridx) < DEPTH) begin
        r.outcome = aht_pkg::OC_READ_OCC;
        slot = int'(ridx);
      end else begin
        r.outcome = aht_pkg::OC_READ_EMPT;
      end
    end else if (key == aht_pkg::KEY_ZERO || key == aht_pkg::KEY_ONES) begin
      r.outcome = aht_pkg::OC_REJECTED;
    end else begin
      for (int i = 0; i < int'(fill_level); i++) begin
        if (slot < 0 && learned_key[i] == key) slot = i;
      end
      if (slot >= 0) begin
        r.outcome           = aht_pkg::OC_MATCHED;
        learned_count[slot] = learned_count[slot] + aht_pkg::CNT_W'(1);
        learned_chan[slot]  = chan;
        learned_seen[slot]  = ts;
        capture_sum         = capture_sum + aht_pkg::CNT_W'(1);
      end else if (int'(fill_level) < DEPTH) begin
        r.outcome           = aht_pkg::OC_INSERTED;
        slot                = int'(fill_level);
        learned_key[slot]   = key;
        learned_chan[slot]  = chan;
        learned_count[slot] = aht_pkg::CNT_W'(1);
        learned_seen[slot]  = ts;
        fill_level          = fill_level + 1;
        capture_sum         = capture_sum + aht_pkg::CNT_W'(1);
      end else begin
        r.outcome = aht_pkg::OC_DROPPED;
      end
    end
    if (slot >= 0) begin
      r.idx   = aht_pkg::IDX_W'(slot);
      r.key   = learned_key[slot];
      r.chan  = learned_chan[slot];
      r.count = learned_count[slot];
      r.seen  = learned_seen[slot];
    end
    // an empty read echoes the requested index
    if (r.outcome == aht_pkg::OC_READ_EMPT) r.idx = ridx;
    r.occ   = aht_pkg::OCC_W'(fill_level);
    r.total = capture_sum;
    return r;
  endfunction

  function automatic string reply_text(hit_reply_t r);
    return $sformatf("oc=%0d idx=%0d key=%h ch=%0d cnt=%0d seen=%h occ=%0d tot=%0d",
                     r.outcome, r.idx, r.key, r.chan, r.count, r.seen, r.occ, r.total);
  endfunction

  function automatic bit same_reply(hit_reply_t e, hit_reply_t a);
    bit ok;
    ok = 1'b1;
    if (e.outcome !== a.outcome) ok = 1'b0;
    if (e.idx     !== a.idx)     ok = 1'b0;
    if (e.key     !== a.key)     ok = 1'b0;
    if (e.chan    !== a.chan)    ok = 1'b0;
    if (e.count   !== a.count)   ok = 1'b0;
    if (e.seen    !== a.seen)    ok = 1'b0;
    if (e.occ     !== a.occ)     ok = 1'b0;
    if (e.total   !== a.total)   ok = 1'b0;
    return ok;
  endfunction

  always @(posedge clk) begin : monitor
    hit_reply_t want;
    hit_reply_t got;
    if (!rst_n) begin
      fill_level  = 0;
      capture_sum = '0;
      bad_words   = 0;
      n_inserted  = 0;
      n_matched   = 0;
      n_dropped   = 0;
      n_rejected  = 0;
      n_reads     = 0;
      replies_due.delete();
    end else begin
      // result side first: a word accepted in this cycle cannot be answered in it
      if (out_mon.valid && out_mon.ready) begin
        got.outcome = aht_pkg::outcome_t'(out_mon.outcome);
        got.idx     = out_mon.entry_index;
        got.key     = out_mon.entry_key;
        got.chan    = out_mon.entry_channel;
        got.count   = out_mon.entry_count;
        got.seen    = out_mon.entry_last_seen;
        got.occ     = out_mon.occupied;
        got.total   = out_mon.total_captured;
        if (replies_due.size() == 0) begin
          bad_words++;
          if (bad_words <= 10) begin
            $display("unexpected result word at %0t", $time);
            $display("  actual   %s", reply_text(got));
          end
        end else begin
          want = replies_due.pop_front();
          if (!same_reply(want, got)) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display("result mismatch at %0t", $time);
              $display("  expected %s", reply_text(want));
              $display("  actual   %s", reply_text(got));
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = table_response(in_mon.command, in_mon.key, in_mon.channel,
                              in_mon.timestamp, in_mon.read_index);
        replies_due.push_back(want);
        case (want.outcome)
          aht_pkg::OC_INSERTED:                       n_inserted++;
          aht_pkg::OC_MATCHED:                        n_matched++;
          aht_pkg::OC_DROPPED:                        n_dropped++;
          aht_pkg::OC_REJECTED:                       n_rejected++;
          aht_pkg::OC_READ_OCC, aht_pkg::OC_READ_EMPT: n_reads++;
          default: ;
        endcase
      end
    end
    pending <= replies_due.size();
  end

endmodule

// ===== test/advertiser_address_hit_table_core_tb.sv =====
// testbench top for the hit table: drives capture and read words, paces both channels, reports
module advertiser_address_hit_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 16;
  localparam int RANDOM_WORDS = 500;
  localparam int LONG_HOLD    = 300;
  // covers the slowest words plus the two long holds, taken several times over
  localparam int CYCLE_LIMIT  = 150000;
  // covers the scan of a full table, with slack
  localparam int DRAIN_CYCLES = 40;

  // a few fixed keys at the edges of the key range
  localparam logic [aht_pkg::KEY_W-1:0] KEY_LOW_ONE  = 48'h0000_0000_0001;
  localparam logic [aht_pkg::KEY_W-1:0] KEY_HIGH_ONE = 48'hFFFF_FFFF_FFFE;
  localparam logic [aht_pkg::KEY_W-1:0] KEY_MSB      = 48'h8000_0000_0000;
  localparam logic [aht_pkg::KEY_W-1:0] KEY_NO_MSB   = 48'h7FFF_FFFF_FFFF;
  localparam logic [aht_pkg::KEY_W-1:0] KEY_NEAR_ONE = 48'h0000_0000_0003;

  logic clk;
  logic rst_n;

  aht_in_if  in_ch ();
  aht_out_if out_ch ();

  int bad_words, pending;
  int n_inserted, n_matched, n_dropped, n_rejected, n_reads;

  // long output stalls asked by the stimulus, served by the result taker
  int hold_requests;
  int cycle_n = 0;
  bit quiet_in;

  advertiser_address_hit_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  aht_hit_checker #(
    .DEPTH(TABLE_DEPTH)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .bad_words  (bad_words),
    .pending    (pending),
    .n_inserted (n_inserted),
    .n_matched  (n_matched),
    .n_dropped  (n_dropped),
    .n_rejected (n_rejected),
    .n_reads    (n_reads)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, counts every clock from the start
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_n, pending);
      $display("FAIL advertiser_address_hit_table_core");
      $finish;
    end
  end

  // any key but the two reserved patterns
  function automatic logic [aht_pkg::KEY_W-1:0] fresh_key();
    logic [aht_pkg::KEY_W-1:0] k;
    k = {16'($urandom), $urandom};
    if (k == aht_pkg::KEY_ZERO || k == aht_pkg::KEY_ONES) k = 48'h1234_5678_9ABC;
    return k;
  endfunction

  // offers one word and holds it until the block takes it, then idles a drawn number of cycles
  task automatic offer_word(input aht_pkg::command_t cmd,
                            input logic [aht_pkg::KEY_W-1:0] key,
                            input logic [aht_pkg::CHAN_W-1:0] chan,
                            input logic [aht_pkg::TIME_W-1:0] ts,
                            input logic [aht_pkg::IDX_W-1:0] ridx);
    int unsigned gap;
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.key        <= key;
    in_ch.channel    <= chan;
    in_ch.timestamp  <= ts;
    in_ch.read_index <= ridx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // now and then switch between back-to-back words and gappy traffic
    if ($urandom_range(0, 31) == 0) quiet_in = !quiet_in;
    gap = quiet_in ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result taker: stalls a drawn number of cycles before each word, or a long
  // stretch when asked, so the block fills up and backs up its input
  initial begin : result_taker
    int unsigned stall;
    int          holds_done;
    bit          quiet_out;
    holds_done = 0;
    quiet_out  = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (holds_done != hold_requests) begin
        holds_done++;
        stall = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 31) == 0) quiet_out = !quiet_out;
        stall = quiet_out ? 0 : $urandom_range(0, 11);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        for (int c = 0; c < stall; c++) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [aht_pkg::KEY_W-1:0]  known_keys[$];
    logic [aht_pkg::KEY_W-1:0]  key;
    logic [aht_pkg::CHAN_W-1:0] chan;
    aht_pkg::command_t          cmd;
    int unsigned                pick;

    hold_requests = 0;
    quiet_in      = 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= aht_pkg::CMD_CAPTURE;
    in_ch.key        <= '0;
    in_ch.channel    <= '0;
    in_ch.timestamp  <= '0;
    in_ch.read_index <= '0;
    rst_n            <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reads of a fresh table come back empty
    offer_word(aht_pkg::CMD_READ, fresh_key(), 6'd0, 32'd0, 4'd0);
    offer_word(aht_pkg::CMD_READ, fresh_key(), 6'd63, 32'hFFFF_FFFF, 4'd15);
    // the two reserved key patterns are turned away
    offer_word(aht_pkg::CMD_CAPTURE, aht_pkg::KEY_ZERO, 6'd63, 32'hFFFF_FFFF, 4'd15);
    offer_word(aht_pkg::CMD_CAPTURE, aht_pkg::KEY_ONES, 6'd0, 32'd0, 4'd0);
    // first learned keys at the edges of the key range
    offer_word(aht_pkg::CMD_CAPTURE, KEY_LOW_ONE, 6'd37, 32'd0, 4'd0);
    offer_word(aht_pkg::CMD_CAPTURE, KEY_HIGH_ONE, 6'd38, 32'hFFFF_FFFF, 4'd15);
    offer_word(aht_pkg::CMD_CAPTURE, KEY_MSB, 6'd0, 32'd1, 4'd7);
    offer_word(aht_pkg::CMD_CAPTURE, KEY_NO_MSB, 6'd63, 32'h8000_0000, 4'd8);
    // repeat hits on the first and the newest entry
    offer_word(aht_pkg::CMD_CAPTURE, KEY_LOW_ONE, 6'd39, 32'h7FFF_FFFF, 4'd1);
    offer_word(aht_pkg::CMD_CAPTURE, KEY_NO_MSB, 6'd0, 32'd0, 4'd2);
    // one bit away from a stored key must not match it
    offer_word(aht_pkg::CMD_CAPTURE, KEY_NEAR_ONE, 6'd21, 32'h5555_AAAA, 4'd5);
    // read back occupied entries and the first free slot
    offer_word(aht_pkg::CMD_READ, fresh_key(), 6'd0, 32'd0, 4'd0);
    offer_word(aht_pkg::CMD_READ, fresh_key(), 6'd0, 32'd0, 4'd3);
    offer_word(aht_pkg::CMD_READ, fresh_key(), 6'd0, 32'd0, 4'd4);
    offer_word(aht_pkg::CMD_READ, fresh_key(), 6'd0, 32'd0, 4'd5);
    offer_word(aht_pkg::CMD_READ, fresh_key(), 6'd0, 32'd0, 4'd15);
    offer_word(aht_pkg::CMD_CAPTURE, KEY_LOW_ONE, 6'd37, 32'hDEAD_BEEF, 4'd9);
    offer_word(aht_pkg::CMD_READ, fresh_key(), 6'd0, 32'd0, 4'd0);

    // key pool: more keys than the table holds, so it fills and later drops
    known_keys.push_back(KEY_LOW_ONE);
    known_keys.push_back(KEY_HIGH_ONE);
    known_keys.push_back(KEY_MSB);
    known_keys.push_back(KEY_NO_MSB);
    for (int i = 0; i < 24; i++) known_keys.push_back(fresh_key());

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // two long output stalls while the input keeps offering
      if (n == 150 || n == 380) hold_requests = hold_requests + 1;
      cmd  = aht_pkg::CMD_CAPTURE;
      key  = fresh_key();
      chan = $urandom_range(0, 1) ? aht_pkg::CHAN_W'($urandom_range(37, 39))
                                  : aht_pkg::CHAN_W'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // half of the words use keys that are or may become table entries
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (pick < 56) begin
        // near miss of a pool key
        key = known_keys[$urandom_range(0, known_keys.size() - 1)]
              ^ (48'd1 << $urandom_range(0, aht_pkg::KEY_W - 1));
      end else if (pick < 68) begin
        // brand new key, inserted while there is room
      end else if (pick < 76) begin
        key = $urandom_range(0, 1) ? aht_pkg::KEY_ZERO : aht_pkg::KEY_ONES;
      end else begin
        cmd = aht_pkg::CMD_READ;
      end
      offer_word(cmd, key, chan, $urandom, aht_pkg::IDX_W'($urandom_range(0, 15)));
    end
    in_ch.valid <= 1'b0;

    // drain: one edge so the outstanding count is current, then wait it out
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts, %0d repeat hits, %0d full-table drops, %0d rejected keys",
             n_inserted, n_matched, n_dropped, n_rejected);
    $display("and %0d read-backs, with %0d long output stalls backing up the input",
             n_reads, hold_requests);
    if (bad_words == 0 && pending == 0) begin
      $display("PASS advertiser_address_hit_table_core");
    end else begin
      $display("FAIL advertiser_address_hit_table_core");
    end
    $finish;
  end

endmodule
